// ===== design/mandelbrot_escape_time_pixel_unit_macros.svh =====
// assertion macros shared by the pixel unit
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MET_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/met_pkg.sv =====
// shared constants, register codes and control types of the pixel unit
package met_pkg;

    localparam int MET_FRAC_BITS   = 26;
    localparam int MET_COORD_WIDTH = 32;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int VIEW_W    = 16;
    localparam int PIX_W     = 16;
    localparam int CNT_W     = 16;

    localparam logic [CFG_W-1:0]  RST_REAL_MIN   = 32'hF800_0000;
    localparam logic [CFG_W-1:0]  RST_REAL_MAX   = 32'h0400_0000;
    localparam logic [CFG_W-1:0]  RST_IMAG_MIN   = 32'hFA00_0000;
    localparam logic [CFG_W-1:0]  RST_IMAG_MAX   = 32'h0600_0000;
    localparam logic [VIEW_W-1:0] RST_VIEW_W     = 16'd1024;
    localparam logic [VIEW_W-1:0] RST_VIEW_H     = 16'd1024;
    localparam logic [CNT_W-1:0]  RST_ITER_LIMIT = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_MIN   = 3'd0,
        CFG_REAL_MAX   = 3'd1,
        CFG_IMAG_MIN   = 3'd2,
        CFG_IMAG_MAX   = 3'd3,
        CFG_VIEW_WIDTH = 3'd4,
        CFG_VIEW_HGT   = 3'd5,
        CFG_ITER_LIMIT = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        AXIS_REAL = 1'b0,
        AXIS_IMAG = 1'b1
    } t_axis;

    typedef struct packed {
        logic  load;
        logic  calc_range;
        t_axis axis;
        logic  prod;
        logic  div_start;
        logic  map_store;
        logic  init;
        logic  square;
        logic  step;
        logic  result_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic finish;
    } t_status;

endpackage

// ===== design/mandelbrot_escape_time_pixel_unit.sv =====
// an input transfer maps both axes through the shared divider (one quotient bit per cycle),
// then iterates until escape or the limit; each iteration runs a square step then an update step
// one pixel is worked on at a time; the next is taken once the result is loaded for output
// a result waits in the output register while the next pixel is taken
// reset (synchronous, active low) loads the default view, clears control, no result pending
`include "mandelbrot_escape_time_pixel_unit_macros.svh"

module mandelbrot_escape_time_pixel_unit
    import met_pkg::*;
#(
    parameter int FRAC_BITS   = MET_FRAC_BITS,
    parameter int COORD_WIDTH = MET_COORD_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel_col,
    input  logic [PIX_W-1:0]     i_pixel_row,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_iteration_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_real_min, r_real_max, r_imag_min, r_imag_max;
    logic [VIEW_W-1:0] r_view_width, r_view_height;
    logic [CNT_W-1:0]  r_iter_limit;

    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_min    <= RST_REAL_MIN;
            r_real_max    <= RST_REAL_MAX;
            r_imag_min    <= RST_IMAG_MIN;
            r_imag_max    <= RST_IMAG_MAX;
            r_view_width  <= RST_VIEW_W;
            r_view_height <= RST_VIEW_H;
            r_iter_limit  <= RST_ITER_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REAL_MIN:   r_real_min    <= i_cfg_data;
                CFG_REAL_MAX:   r_real_max    <= i_cfg_data;
                CFG_IMAG_MIN:   r_imag_min    <= i_cfg_data;
                CFG_IMAG_MAX:   r_imag_max    <= i_cfg_data;
                CFG_VIEW_WIDTH: r_view_width  <= i_cfg_data[VIEW_W-1:0];
                CFG_VIEW_HGT:   r_view_height <= i_cfg_data[VIEW_W-1:0];
                CFG_ITER_LIMIT: r_iter_limit  <= i_cfg_data[CNT_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    met_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_pixel_col       (i_pixel_col),
        .i_pixel_row       (i_pixel_row),
        .i_real_min        (r_real_min),
        .i_real_max        (r_real_max),
        .i_imag_min        (r_imag_min),
        .i_imag_max        (r_imag_max),
        .i_view_width      (r_view_width),
        .i_view_height     (r_view_height),
        .i_iter_limit      (r_iter_limit),
        .o_iteration_count (o_iteration_count)
    );

    // one pixel in flight: a transfer in closes the input until the result is loaded for output
    `MET_ASSERT_NEXT(a_in_closes, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a count never exceeds the limit
    `MET_ASSERT_IMPLY(a_count_limit, i_clk, i_rst_n, o_out_valid, o_iteration_count <= r_iter_limit)
    // a result only appears after a pixel was being worked on
    `MET_ASSERT_IMPLY(a_result_source, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

// ===== design/met_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module met_div
    import met_pkg::*;
#(
    parameter int NUM_W = MET_COORD_WIDTH + 16,
    parameter int DEN_W = VIEW_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_BW = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_BW-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_BW'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BW'(1);
            if (r_cnt == CNT_BW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the low bits
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== design/met_ctrl.sv =====
// sequencer for mapping, iteration and result handoff
module met_ctrl
    import met_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANGE,
        S_PROD,
        S_DIV,
        S_WAIT,
        S_MAP,
        S_INIT,
        S_SQ,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state;
    t_axis  r_axis;
    logic   r_out_valid;

    logic   in_xfer;
    logic   out_xfer;
    logic   out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE:  o_cmd.load        = in_xfer;
            S_RANGE: o_cmd.calc_range  = 1'b1;
            S_PROD:  o_cmd.prod        = 1'b1;
            S_DIV:   o_cmd.div_start   = 1'b1;
            S_MAP:   o_cmd.map_store   = 1'b1;
            S_INIT:  o_cmd.init        = 1'b1;
            S_SQ:    o_cmd.square      = 1'b1;
            S_UPD:   o_cmd.step        = !i_status.finish;
            S_DONE:  o_cmd.result_load = out_free;
            default: o_cmd             = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_REAL;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    r_axis  <= AXIS_REAL;
                    r_state <= S_PROD;
                end
                S_PROD: r_state <= S_DIV;
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    if (r_axis == AXIS_REAL) begin
                        r_axis  <= AXIS_IMAG;
                        r_state <= S_PROD;
                    end else begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_SQ;
                S_SQ:   r_state <= S_UPD;
                S_UPD: begin
                    r_state <= i_status.finish ? S_DONE : S_SQ;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/met_dp.sv =====
// datapath: pixel to point mapping and the z^2 + c iteration
module met_dp
    import met_pkg::*;
#(
    parameter int FRAC_BITS   = MET_FRAC_BITS,
    parameter int COORD_WIDTH = MET_COORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [PIX_W-1:0]  i_pixel_col,
    input  logic [PIX_W-1:0]  i_pixel_row,
    input  logic [CFG_W-1:0]  i_real_min,
    input  logic [CFG_W-1:0]  i_real_max,
    input  logic [CFG_W-1:0]  i_imag_min,
    input  logic [CFG_W-1:0]  i_imag_max,
    input  logic [VIEW_W-1:0] i_view_width,
    input  logic [VIEW_W-1:0] i_view_height,
    input  logic [CNT_W-1:0]  i_iter_limit,
    output logic [CNT_W-1:0]  o_iteration_count
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = (CW > CFG_W) ? CW : CFG_W;
    localparam int PW   = 2 * CW;
    localparam int MW   = CW + PIX_W + 1;
    localparam int DVW  = MW - 1;
    localparam int CMPW = (CW > FRAC_BITS + 3) ? CW + 1 : FRAC_BITS + 4;

    localparam logic signed [CW-1:0]   CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]   CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CMPW-1:0] FOUR = CMPW'(4) << FRAC_BITS;

    function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
        return s[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} - {b[CW-1], b};
        if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
        return s[CW-1:0];
    endfunction

    // register value into coordinate range
    function automatic logic signed [CW-1:0] clamp_cfg(input logic [CFG_W-1:0] raw);
        logic signed [EW-1:0] e;
        logic [EW-CW:0]       hi;
        e  = EW'(signed'(raw));
        hi = e[EW-1:CW-1];
        if ((&hi) || !(|hi)) return e[CW-1:0];
        return e[EW-1] ? CMIN : CMAX;
    endfunction

    function automatic logic signed [CW-1:0] sat_pw(input logic signed [PW-1:0] v);
        logic [PW-CW:0] hi;
        hi = v[PW-1:CW-1];
        if ((&hi) || !(|hi)) return v[CW-1:0];
        return v[PW-1] ? CMIN : CMAX;
    endfunction

    function automatic logic signed [CW-1:0] sat_mw(input logic signed [MW-1:0] v);
        logic [MW-CW:0] hi;
        hi = v[MW-1:CW-1];
        if ((&hi) || !(|hi)) return v[CW-1:0];
        return v[MW-1] ? CMIN : CMAX;
    endfunction

    logic signed [CW-1:0] real_min_c, real_max_c, imag_min_c, imag_max_c;

    assign real_min_c = clamp_cfg(i_real_min);
    assign real_max_c = clamp_cfg(i_real_max);
    assign imag_min_c = clamp_cfg(i_imag_min);
    assign imag_max_c = clamp_cfg(i_imag_max);

    logic [PIX_W-1:0]     r_px, r_py;
    logic signed [CW-1:0] r_rng_x, r_rng_y;
    logic signed [MW-1:0] r_prod;
    logic signed [CW-1:0] r_cx, r_cy, r_x, r_y;
    logic signed [PW-1:0] r_pxx, r_pyy, r_pxy;
    logic [CNT_W-1:0]     r_iter;
    logic [CNT_W-1:0]     r_result;

    // mapping path, shared by both axes
    logic [PIX_W-1:0]     pix_sel;
    logic signed [CW-1:0] rng_sel, lo_sel;
    logic [VIEW_W-1:0]    view_sel, den;
    logic signed [MW-1:0] mul_a, mul_b, prod;
    logic signed [MW-1:0] prod_mag, quo_ext, quo_signed;
    logic                 prod_neg;
    logic                 div_done;
    logic [DVW-1:0]       quot;
    logic signed [CW-1:0] c_new;

    assign pix_sel  = (i_cmd.axis == AXIS_IMAG) ? r_py : r_px;
    assign rng_sel  = (i_cmd.axis == AXIS_IMAG) ? r_rng_y : r_rng_x;
    assign lo_sel   = (i_cmd.axis == AXIS_IMAG) ? imag_min_c : real_min_c;
    assign view_sel = (i_cmd.axis == AXIS_IMAG) ? i_view_height : i_view_width;
    assign den      = (view_sel == '0) ? VIEW_W'(1) : view_sel;

    assign mul_a = $signed(MW'(pix_sel));
    assign mul_b = MW'(rng_sel);
    assign prod  = mul_a * mul_b;

    assign prod_neg   = r_prod[MW-1];
    assign prod_mag   = prod_neg ? -r_prod : r_prod;
    assign quo_ext    = $signed({1'b0, quot});
    assign quo_signed = prod_neg ? -quo_ext : quo_ext;
    assign c_new      = sat_add(lo_sel, sat_mw(quo_signed));

    met_div #(
        .NUM_W (DVW),
        .DEN_W (VIEW_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (prod_mag[DVW-1:0]),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // iteration path
    logic signed [CW-1:0]   x2, y2, xy2, mag, x_next, y_next;
    logic signed [CMPW-1:0] mag_ext;
    logic                   escaped;

    assign x2      = sat_pw(r_pxx >>> FRAC_BITS);
    assign y2      = sat_pw(r_pyy >>> FRAC_BITS);
    assign xy2     = sat_pw(r_pxy >>> (FRAC_BITS - 1));
    assign mag     = sat_add(x2, y2);
    assign mag_ext = CMPW'(mag);
    assign escaped = mag_ext > FOUR;
    assign x_next  = sat_add(sat_sub(x2, y2), r_cx);
    assign y_next  = sat_add(xy2, r_cy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_col;
            r_py <= i_pixel_row;
        end
        if (i_cmd.calc_range) begin
            r_rng_x <= sat_sub(real_max_c, real_min_c);
            r_rng_y <= sat_sub(imag_max_c, imag_min_c);
        end
        if (i_cmd.prod) begin
            r_prod <= prod;
        end
        if (i_cmd.map_store) begin
            if (i_cmd.axis == AXIS_IMAG) begin
                r_cy <= c_new;
            end else begin
                r_cx <= c_new;
            end
        end
        if (i_cmd.init) begin
            r_x    <= r_cx;
            r_y    <= r_cy;
            r_iter <= '0;
        end else if (i_cmd.step) begin
            r_x    <= x_next;
            r_y    <= y_next;
            r_iter <= r_iter + CNT_W'(1);
        end
        if (i_cmd.square) begin
            r_pxx <= PW'(r_x) * PW'(r_x);
            r_pyy <= PW'(r_y) * PW'(r_y);
            r_pxy <= PW'(r_x) * PW'(r_y);
        end
        if (i_cmd.result_load) begin
            r_result <= r_iter;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.finish   = escaped || (r_iter >= i_iter_limit);
    assign o_iteration_count = r_result;

endmodule

// ===== bench/mandelbrot_escape_time_pixel_unit_tb.sv =====
// self-checking bench for the mandelbrot escape-time pixel unit: directed table then random views
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit_tb;
    import met_pkg::*;

    localparam int     CYCLE_LIMIT   = 10_000_000;
    localparam int     DRAIN_CYCLES  = 2 * MET_COORD_WIDTH + 150;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     RANDOM_PHASES = 14;
    localparam int     PHASE_ITEMS   = 130;
    localparam int     FIX_ONE       = 1 << MET_FRAC_BITS;
    localparam longint COORD_MAX     = (longint'(1) << (MET_COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam longint RADIUS_SQ     = longint'(4) << MET_FRAC_BITS;
    localparam bit     TYPED         = 1'b1;
    localparam bit     COMPUTED      = 1'b0;

    // the one index the 3-bit register address can carry with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
    } t_count_due;

    typedef struct {
        bit                   is_cfg;
        bit                   known;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [PIX_W-1:0]     col;
        logic [PIX_W-1:0]     row;
        logic [CNT_W-1:0]     count;
    } t_stim_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [PIX_W-1:0]     pixel_col = '0;
    logic [PIX_W-1:0]     pixel_row = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_REAL_MIN;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [CNT_W-1:0]     o_iteration_count;

    // register mirror used by the predictor
    logic [CFG_W-1:0]  view_re_min = RST_REAL_MIN;
    logic [CFG_W-1:0]  view_re_max = RST_REAL_MAX;
    logic [CFG_W-1:0]  view_im_min = RST_IMAG_MIN;
    logic [CFG_W-1:0]  view_im_max = RST_IMAG_MAX;
    logic [VIEW_W-1:0] view_cols   = RST_VIEW_W;
    logic [VIEW_W-1:0] view_rows   = RST_VIEW_H;
    logic [CNT_W-1:0]  iter_cap    = RST_ITER_LIMIT;

    t_count_due  pending_counts[$];
    t_stim_row   directed[$];
    int          mismatches  = 0;
    int          cycles      = 0;
    int          burst_left  = 0;
    int          hold_asks   = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    mandelbrot_escape_time_pixel_unit i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_col       (pixel_col),
        .i_pixel_row       (pixel_row),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_iteration_count (o_iteration_count),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // exact product, floor shift back to the fraction, then clamp
    function automatic longint fixed_mul(input longint a, input longint b, input int sh);
        return sat_coord((a * b) >>> sh);
    endfunction

    function automatic longint map_pixel(input logic [PIX_W-1:0] pix,
                                         input logic [CFG_W-1:0] lo_reg,
                                         input logic [CFG_W-1:0] hi_reg,
                                         input logic [VIEW_W-1:0] size);
        longint lo, hi, span, pos, divisor;
        lo      = sat_coord(longint'($signed(lo_reg)));
        hi      = sat_coord(longint'($signed(hi_reg)));
        span    = sat_coord(hi - lo);
        pos     = longint'(pix);
        // an empty view divides as a single pixel
        divisor = (size == 0) ? longint'(1) : longint'(size);
        return sat_coord(lo + sat_coord(pos * span / divisor));
    endfunction

    function automatic logic [CNT_W-1:0] escape_count(input logic [PIX_W-1:0] col,
                                                      input logic [PIX_W-1:0] row);
        longint      cx, cy, x, y, x2, y2, x_next;
        int unsigned iter;
        cx   = map_pixel(col, view_re_min, view_re_max, view_cols);
        cy   = map_pixel(row, view_im_min, view_im_max, view_rows);
        x    = cx;
        y    = cy;
        x2   = fixed_mul(x, x, MET_FRAC_BITS);
        y2   = fixed_mul(y, y, MET_FRAC_BITS);
        iter = 0;
        while (sat_coord(x2 + y2) <= RADIUS_SQ && iter < iter_cap) begin
            x_next = sat_coord(sat_coord(x2 - y2) + cx);
            // one bit less of shift gives 2*x*y
            y      = sat_coord(fixed_mul(x, y, MET_FRAC_BITS - 1) + cy);
            x      = x_next;
            x2     = fixed_mul(x, x, MET_FRAC_BITS);
            y2     = fixed_mul(y, y, MET_FRAC_BITS);
            iter++;
        end
        return CNT_W'(iter);
    endfunction

    function automatic int random_span();
        // a quarter of the spans are deep zooms where the divide truncation shows
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(1, 65536));
        return int'($urandom_range(1, 3 * FIX_ONE));
    endfunction

    function automatic logic [VIEW_W-1:0] random_view();
        int pick;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return VIEW_W'($urandom_range(1, 800));
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_stim_row r;
        r.is_cfg = 1'b1;
        r.known  = 1'b0;
        r.idx    = idx;
        r.data   = data;
        r.col    = '0;
        r.row    = '0;
        r.count  = '0;
        directed.push_back(r);
    endfunction

    function automatic void add_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                                      input bit known, input logic [CNT_W-1:0] count);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.known  = known;
        r.idx    = CFG_REAL_MIN;
        r.data   = '0;
        r.col    = col;
        r.row    = row;
        r.count  = count;
        directed.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_REAL_MIN:   view_re_min = data;
            CFG_REAL_MAX:   view_re_max = data;
            CFG_IMAG_MIN:   view_im_min = data;
            CFG_IMAG_MAX:   view_im_max = data;
            CFG_VIEW_WIDTH: view_cols   = data[VIEW_W-1:0];
            CFG_VIEW_HGT:   view_rows   = data[VIEW_W-1:0];
            CFG_ITER_LIMIT: iter_cap    = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // drop valid and let every outstanding count come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_counts.size() != 0);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                              input bit known, input logic [CNT_W-1:0] count);
        t_count_due due;
        int         gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 24));
            gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 24));
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do @(posedge clk); while (o_in_stall);
        burst_left--;
        due.col   = col;
        due.row   = row;
        due.count = known ? count : escape_count(col, row);
        pending_counts.push_back(due);
    endtask

    // receiver: stall pattern of its own, plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 2));
                mode_left  <= int'($urandom_range(16, 256));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_counts
        t_count_due due;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("count %0d transferred with none pending",
                                          o_iteration_count));
            end else begin
                due = pending_counts.pop_front();
                if (o_iteration_count !== due.count)
                    report_mismatch($sformatf("pixel (%0d,%0d): count %0d, want %0d",
                                              due.col, due.row, o_iteration_count, due.count));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d counts outstanding", pending_counts.size());
            $display("[mandelbrot_escape_time_pixel_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int               phase;
        int               re_lo, re_hi, im_lo, im_hi;
        int               col_top, row_top;
        logic [PIX_W-1:0] col, row;

        // default view: corners and far pixels escape at once
        add_pixel(16'd0, 16'd0, TYPED, 16'd0);
        add_pixel(16'hFFFF, 16'hFFFF, TYPED, 16'd0);
        add_pixel(16'hFFFF, 16'd0, TYPED, 16'd0);
        add_pixel(16'd0, 16'hFFFF, TYPED, 16'd0);
        add_pixel(16'd512, 16'd512, COMPUTED, '0);
        add_pixel(16'd700, 16'd600, COMPUTED, '0);
        add_pixel(16'd300, 16'd500, COMPUTED, '0);
        add_pixel(16'd1023, 16'd1023, COMPUTED, '0);
        // zero limit, upper data bits are dropped
        add_cfg(CFG_ITER_LIMIT, 32'hFFFF_0000);
        add_pixel(16'd512, 16'd512, TYPED, 16'd0);
        add_pixel(16'd12345, 16'd54321, TYPED, 16'd0);
        // view collapsed onto the origin never escapes
        add_cfg(CFG_REAL_MIN, '0);
        add_cfg(CFG_REAL_MAX, '0);
        add_cfg(CFG_IMAG_MIN, '0);
        add_cfg(CFG_IMAG_MAX, '0);
        add_cfg(CFG_ITER_LIMIT, 32'h0000_FFFF);
        add_pixel(16'd40000, 16'd20000, TYPED, 16'hFFFF);
        add_cfg(CFG_ITER_LIMIT, 32'h5A5A_0007);
        add_cfg(CFG_UNUSED_INDEX, 32'h7FFF_FFFF);
        add_pixel(16'd1, 16'd1, TYPED, 16'd7);
        // empty view sizes divide by one
        add_cfg(CFG_REAL_MIN, RST_REAL_MIN);
        add_cfg(CFG_REAL_MAX, RST_REAL_MAX);
        add_cfg(CFG_IMAG_MIN, RST_IMAG_MIN);
        add_cfg(CFG_IMAG_MAX, RST_IMAG_MAX);
        add_cfg(CFG_VIEW_WIDTH, 32'hA5A5_0000);
        add_cfg(CFG_VIEW_HGT, '0);
        add_cfg(CFG_ITER_LIMIT, {16'h0000, RST_ITER_LIMIT});
        add_pixel(16'd0, 16'd0, TYPED, 16'd0);
        add_pixel(16'd1, 16'd1, COMPUTED, '0);
        add_pixel(16'd1, 16'd0, COMPUTED, '0);
        // min above max on both axes
        add_cfg(CFG_REAL_MIN, RST_REAL_MAX);
        add_cfg(CFG_REAL_MAX, RST_REAL_MIN);
        add_cfg(CFG_IMAG_MIN, RST_IMAG_MAX);
        add_cfg(CFG_IMAG_MAX, RST_IMAG_MIN);
        add_cfg(CFG_VIEW_WIDTH, {16'h0000, RST_VIEW_W});
        add_cfg(CFG_VIEW_HGT, {16'h0000, RST_VIEW_H});
        add_pixel(16'd512, 16'd512, COMPUTED, '0);
        add_pixel(16'd900, 16'd100, COMPUTED, '0);
        add_pixel(16'd200, 16'd800, COMPUTED, '0);
        // widest edges, range saturates
        add_cfg(CFG_REAL_MIN, 32'h8000_0000);
        add_cfg(CFG_REAL_MAX, 32'h7FFF_FFFF);
        add_cfg(CFG_IMAG_MIN, 32'h7FFF_FFFF);
        add_cfg(CFG_IMAG_MAX, 32'h8000_0000);
        add_cfg(CFG_VIEW_WIDTH, 32'hFFFF_FFFF);
        add_cfg(CFG_VIEW_HGT, 32'h0000_FFFF);
        add_pixel(16'd32767, 16'd32768, COMPUTED, '0);
        add_pixel(16'd32768, 16'd32767, COMPUTED, '0);
        add_pixel(16'hFFFF, 16'hFFFF, COMPUTED, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                wait_idle();
                write_reg(directed[k].idx, directed[k].data);
            end else begin
                push_pixel(directed[k].col, directed[k].row, directed[k].known,
                           directed[k].count);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            if (phase == 1 || $urandom_range(0, 4) == 0) begin
                // raw register contents
                write_reg(CFG_REAL_MIN, $urandom());
                write_reg(CFG_REAL_MAX, $urandom());
                write_reg(CFG_IMAG_MIN, $urandom());
                write_reg(CFG_IMAG_MAX, $urandom());
                write_reg(CFG_VIEW_WIDTH, $urandom());
                write_reg(CFG_VIEW_HGT, $urandom());
                write_reg(CFG_ITER_LIMIT, {16'($urandom()), 16'($urandom_range(0, 128))});
                write_reg(CFG_UNUSED_INDEX, $urandom());
            end else begin
                // a window somewhere over the set, sometimes flipped
                re_lo = int'($urandom_range(0, 3 * FIX_ONE)) - 5 * FIX_ONE / 2;
                re_hi = re_lo + random_span();
                im_lo = int'($urandom_range(0, 3 * FIX_ONE)) - 3 * FIX_ONE / 2;
                im_hi = im_lo + random_span();
                if ($urandom_range(0, 5) == 0) {re_lo, re_hi} = {re_hi, re_lo};
                if ($urandom_range(0, 5) == 0) {im_lo, im_hi} = {im_hi, im_lo};
                write_reg(CFG_REAL_MIN, re_lo);
                write_reg(CFG_REAL_MAX, re_hi);
                write_reg(CFG_IMAG_MIN, im_lo);
                write_reg(CFG_IMAG_MAX, im_hi);
                write_reg(CFG_VIEW_WIDTH, {16'($urandom()), random_view()});
                write_reg(CFG_VIEW_HGT, {16'($urandom()), random_view()});
                if ($urandom_range(0, 4) == 0)
                    write_reg(CFG_ITER_LIMIT, {16'($urandom()), RST_ITER_LIMIT});
                else
                    write_reg(CFG_ITER_LIMIT, {16'($urandom()), 16'($urandom_range(0, 96))});
            end
            // receiver sits on a count long enough for the unit to back up
            if (phase % 6 == 2) hold_asks <= hold_asks + 1;
            col_top = (view_cols == 0) ? 0 : int'(view_cols) - 1;
            row_top = (view_rows == 0) ? 0 : int'(view_rows) - 1;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    col = 16'($urandom());
                    row = 16'($urandom());
                end else begin
                    col = 16'($urandom_range(0, col_top));
                    row = 16'($urandom_range(0, row_top));
                end
                push_pixel(col, row, COMPUTED, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[mandelbrot_escape_time_pixel_unit] OK");
        else
            $display("[mandelbrot_escape_time_pixel_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/met_pkg.sv
design/met_div.sv
design/met_ctrl.sv
design/met_dp.sv
design/mandelbrot_escape_time_pixel_unit.sv
bench/mandelbrot_escape_time_pixel_unit_tb.sv
